>>> hw/rtl/rvf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring FIFO package
// Shared widths, operation and status codes, and the item types that pass
// between the front and back parts of the record ring FIFO.
// ----------------------------------------------------------------------------
package rvf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 512;
   localparam int unsigned MAX_RECORD    = 64;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned LEN_W    = 7;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Decoded command as it waits in the command queue.
   typedef struct packed {
      logic              is_push;
      logic              is_pop;
      logic              is_peek;
      logic              is_clear;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  length;
   } cmd_type;

   // One result item, apart from the free byte count whose width follows DEPTH.
   typedef struct packed {
      status_type        status;
      logic [BYTE_W-1:0] out_byte;
      logic              has_data;
      logic [LEN_W-1:0]  stored_length;
      logic              last;
      logic              is_empty;
   } rsp_type;

endpackage

>>> hw/rtl/variable_record_ring_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-length record ring FIFO
// A byte ring that stores records as a one-byte length header plus payload,
// with push, pop, peek and clear operations and queue-style ports.
// ----------------------------------------------------------------------------
// Push, clear and empty-read results go from the idle state straight into
// the result register; a pop or peek reads the header, then streams bytes.
// A first push byte with payload writes the header, then the byte in S_DATA
// (one ring write port); the engine takes a new command only back in idle.
// Synchronous reset clears pointers, pending push and result valid and sets the
// free count to DEPTH; the ring contents are left as they are.
module variable_record_ring_fifo_top #(
   parameter  int unsigned DEPTH = rvf_pkg::DEPTH_DEFAULT,
   localparam int unsigned FW    = $clog2(DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   // Input items.
   input  logic                          push,
   output logic                          full,
   input  logic [rvf_pkg::OP_W-1:0]      req_operation,
   input  logic [rvf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [rvf_pkg::LEN_W-1:0]     req_length,
   // Result items.
   output logic                          empty,
   input  logic                          pop,
   output logic [rvf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [rvf_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_has_data,
   output logic [rvf_pkg::LEN_W-1:0]     rsp_stored_length,
   output logic                          rsp_last,
   output logic [FW-1:0]                 rsp_free_bytes,
   output logic                          rsp_is_empty
);
   import rvf_pkg::*;

   // Command queue between the decoding front end and the ring engine.
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   // Result output register of the engine.
   logic    rsp_valid;
   rsp_type rsp;

   rvf_front u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .req_length    (req_length),
      .full          (full),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   // The engine only starts a command when its output register can take the
   // next result, so a waiting result stalls the engine while the front end
   // keeps accepting items into its queue.
   rvf_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_take  (pop),
      .rsp       (rsp),
      .rsp_free  (rsp_free_bytes)
   );

   // The oldest waiting result item sits on the result ports while empty is low.
   assign empty             = !rsp_valid;
   assign rsp_status        = rsp.status;
   assign rsp_out_byte      = rsp.out_byte;
   assign rsp_has_data      = rsp.has_data;
   assign rsp_stored_length = rsp.stored_length;
   assign rsp_last          = rsp.last;
   assign rsp_is_empty      = rsp.is_empty;

endmodule

>>> hw/rtl/rvf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring FIFO front end
// Accepts input items, decodes the operation and holds the decoded commands
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rvf_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  logic [rvf_pkg::OP_W-1:0]      req_operation,
   input  logic [rvf_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [rvf_pkg::LEN_W-1:0]     req_length,
   output logic                          full,
   output logic                          cmd_valid,
   output rvf_pkg::cmd_type              cmd,
   input  logic                          cmd_take
);
   import rvf_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_idx_ff, wr_idx_in;
   logic       rd_idx_ff, rd_idx_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   cmd_type    dec;

   assign full      = (count_ff == 2'd2);
   assign accept    = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_idx_ff];

   always_comb begin
      dec           = '0;
      dec.data_byte = req_data_byte;
      dec.length    = req_length;
      unique case (op_type'(req_operation))
         OP_PUSH:  dec.is_push  = 1'b1;
         OP_POP:   dec.is_pop   = 1'b1;
         OP_PEEK:  dec.is_peek  = 1'b1;
         OP_CLEAR: dec.is_clear = 1'b1;
         default:  dec.is_clear = 1'b1;
      endcase
   end

   always_comb begin
      wr_idx_in = accept   ? ~wr_idx_ff : wr_idx_ff;
      rd_idx_in = cmd_take ? ~rd_idx_ff : rd_idx_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, cmd_take};
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff[wr_idx_ff] <= dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hw/rtl/rvf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record ring FIFO back end
// Owns the byte ring, the pointers and the free count, carries out one
// command at a time and drives the result output register.
// ----------------------------------------------------------------------------
module rvf_back #(
   parameter  int unsigned DEPTH = rvf_pkg::DEPTH_DEFAULT,
   localparam int unsigned AW    = $clog2(DEPTH),
   localparam int unsigned FW    = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  rvf_pkg::cmd_type cmd,
   output logic             cmd_take,
   output logic             rsp_valid,
   input  logic             rsp_take,
   output rvf_pkg::rsp_type rsp,
   output logic [FW-1:0]    rsp_free
);
   import rvf_pkg::*;

   localparam logic [AW+1:0] DEPTH_S = (AW+2)'(DEPTH);
   localparam logic [FW-1:0] DEPTH_F = FW'(DEPTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_DATA   = 4'b0010,
      S_HEADER = 4'b0100,
      S_STREAM = 4'b1000
   } state_type;

   function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] p, logic [8:0] n);
      logic [AW+1:0] s;
      s = {2'b00, p} + (AW+2)'(n);
      if (s >= DEPTH_S) s = s - DEPTH_S;
      if (s >= DEPTH_S) s = s - DEPTH_S;
      return s[AW-1:0];
   endfunction

   function automatic logic [AW-1:0] wrap_sub(logic [AW-1:0] p, logic [LEN_W-1:0] n);
      logic [AW+1:0] s;
      s = {2'b00, p} + DEPTH_S - (AW+2)'(n);
      if (s >= DEPTH_S) s = s - DEPTH_S;
      return s[AW-1:0];
   endfunction

   state_type          state_ff, state_in;
   logic [AW-1:0]      rp_ff, rp_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [FW-1:0]      free_ff, free_in;
   logic [LEN_W-1:0]   prem_ff, prem_in;
   logic               prej_ff, prej_in;
   logic [BYTE_W-1:0]  hdr_ff, hdr_in;
   logic [LEN_W-1:0]   cap_ff, cap_in;
   logic               remove_ff, remove_in;
   logic [LEN_W-1:0]   left_ff, left_in;
   logic [AW-1:0]      next_ff, next_in;
   logic [BYTE_W-1:0]  wbyte_ff, wbyte_in;
   logic [AW-1:0]      waddr2_ff, waddr2_in;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_ff, out_in;
   logic [FW-1:0]      out_free_ff, out_free_in;

   logic [BYTE_W-1:0]  ring_mem [DEPTH];
   logic [BYTE_W-1:0]  rdata_ff;
   logic               we, re;
   logic [AW-1:0]      waddr, raddr;
   logic [BYTE_W-1:0]  wdata;

   logic               adv, emit;
   rsp_type            emit_rsp;
   logic [7:0]         len_p1;
   logic               too_big;
   logic [7:0]         n8;
   logic [LEN_W-1:0]   n_emit;
   logic [FW:0]        free_sum;

   assign adv       = !out_valid_ff || rsp_take;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;
   assign rsp_free  = out_free_ff;

   assign len_p1  = {1'b0, cmd.length} + 8'd1;
   assign too_big = (cmd.length > LEN_W'(MAX_RECORD)) || ({{(FW-8){1'b0}}, len_p1} > free_ff);

   // Bytes to emit for the record whose header sits in the read data register.
   always_comb begin
      n8 = (rdata_ff < {1'b0, cap_ff}) ? rdata_ff : {1'b0, cap_ff};
      if (n8 > 8'(MAX_RECORD)) n8 = 8'(MAX_RECORD);
      n_emit   = n8[LEN_W-1:0];
      free_sum = {1'b0, free_ff} + (FW+1)'(rdata_ff) + (FW+1)'(1);
   end

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      free_in      = free_ff;
      prem_in      = prem_ff;
      prej_in      = prej_ff;
      hdr_in       = hdr_ff;
      cap_in       = cap_ff;
      remove_in    = remove_ff;
      left_in      = left_ff;
      next_in      = next_ff;
      wbyte_in     = wbyte_ff;
      waddr2_in    = waddr2_ff;
      out_valid_in = out_valid_ff && !rsp_take;
      out_in       = out_ff;
      out_free_in  = out_free_ff;
      cmd_take     = 1'b0;
      we           = 1'b0;
      re           = 1'b0;
      waddr        = wp_ff;
      raddr        = rp_ff;
      wdata        = cmd.data_byte;
      emit         = 1'b0;
      emit_rsp     = '0;
      emit_rsp.status = STATUS_OK;
      emit_rsp.last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && adv) begin
               cmd_take = 1'b1;
               priority if (cmd.is_push) begin
                  emit = 1'b1;
                  if (prem_ff != '0) begin
                     // Continuation byte of a record already reserved or refused.
                     if (prej_ff) begin
                        emit_rsp.status = STATUS_FULL;
                     end else begin
                        we    = 1'b1;
                        waddr = wrap_sub(wp_ff, prem_ff);
                     end
                     prem_in = prem_ff - LEN_W'(1);
                     if (prem_ff == LEN_W'(1)) prej_in = 1'b0;
                  end else if (too_big) begin
                     emit_rsp.status = STATUS_FULL;
                     prem_in = (cmd.length != '0) ? cmd.length - LEN_W'(1) : '0;
                     prej_in = (cmd.length > LEN_W'(1));
                  end else begin
                     // Record start: header now, first payload byte next cycle.
                     we      = 1'b1;
                     waddr   = wp_ff;
                     wdata   = {1'b0, cmd.length};
                     wp_in   = wrap_add(wp_ff, {1'b0, len_p1});
                     free_in = free_ff - FW'(len_p1);
                     prem_in = (cmd.length != '0) ? cmd.length - LEN_W'(1) : '0;
                     prej_in = 1'b0;
                     if (cmd.length != '0) begin
                        wbyte_in  = cmd.data_byte;
                        waddr2_in = wrap_add(wp_ff, 9'd1);
                        state_in  = S_DATA;
                     end
                  end
               end else if (cmd.is_pop || cmd.is_peek) begin
                  if (free_ff == DEPTH_F) begin
                     emit            = 1'b1;
                     emit_rsp.status = STATUS_EMPTY;
                  end else begin
                     re        = 1'b1;
                     raddr     = rp_ff;
                     cap_in    = cmd.length;
                     remove_in = cmd.is_pop;
                     next_in   = wrap_add(rp_ff, 9'd1);
                     state_in  = S_HEADER;
                  end
               end else begin
                  emit    = 1'b1;
                  rp_in   = wp_ff;
                  free_in = DEPTH_F;
                  prem_in = '0;
                  prej_in = 1'b0;
               end
            end
         end
         S_DATA: begin
            we       = 1'b1;
            waddr    = waddr2_ff;
            wdata    = wbyte_ff;
            state_in = S_IDLE;
         end
         S_HEADER: begin
            if (n_emit == '0) begin
               if (adv) begin
                  emit                   = 1'b1;
                  emit_rsp.stored_length = rdata_ff[LEN_W-1:0];
                  state_in               = S_IDLE;
               end
            end else begin
               re       = 1'b1;
               raddr    = next_ff;
               next_in  = wrap_add(next_ff, 9'd1);
               left_in  = n_emit;
               hdr_in   = rdata_ff;
               state_in = S_STREAM;
            end
            // Pop removes header plus stored length once, on leaving this state.
            if (remove_ff && (state_in != S_HEADER)) begin
               rp_in   = wrap_add(rp_ff, {1'b0, rdata_ff} + 9'd1);
               free_in = (free_sum > (FW+1)'(DEPTH)) ? DEPTH_F : free_sum[FW-1:0];
            end
         end
         S_STREAM: begin
            if (adv) begin
               emit                   = 1'b1;
               emit_rsp.out_byte      = rdata_ff;
               emit_rsp.has_data      = 1'b1;
               emit_rsp.stored_length = hdr_ff[LEN_W-1:0];
               emit_rsp.last          = (left_ff == LEN_W'(1));
               if (left_ff != LEN_W'(1)) begin
                  re      = 1'b1;
                  raddr   = next_ff;
                  next_in = wrap_add(next_ff, 9'd1);
                  left_in = left_ff - LEN_W'(1);
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (emit) begin
         emit_rsp.is_empty = (free_in == DEPTH_F);
         out_valid_in      = 1'b1;
         out_in            = emit_rsp;
         out_free_in       = free_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ring_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= ring_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff      <= hdr_in;
      cap_ff      <= cap_in;
      remove_ff   <= remove_in;
      left_ff     <= left_in;
      next_ff     <= next_in;
      wbyte_ff    <= wbyte_in;
      waddr2_ff   <= waddr2_in;
      out_ff      <= out_in;
      out_free_ff <= out_free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         free_ff      <= DEPTH_F;
         prem_ff      <= '0;
         prej_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         free_ff      <= free_in;
         prem_ff      <= prem_in;
         prej_ff      <= prej_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // The free count never exceeds the ring size.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= DEPTH_F)
      else $error("free count above ring size");

   // A refused record always has bytes left to refuse.
   a_reject_pending: assert property (@(posedge clock) disable iff (reset)
      prej_ff |-> (prem_ff != '0))
      else $error("rejecting with no bytes pending");

   // Streaming always has at least one byte left to send.
   a_stream_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STREAM) |-> (left_ff != '0))
      else $error("stream state with nothing left");

   // The single ring port is never asked to write and read in one cycle.
   a_port_conflict: assert property (@(posedge clock) disable iff (reset)
      !(we && re))
      else $error("ring write and read in the same cycle");

   // A clear leaves the whole ring free.
   a_clear_frees: assert property (@(posedge clock) disable iff (reset)
      (cmd_take && cmd.is_clear) |=> (free_ff == DEPTH_F))
      else $error("clear did not free the ring");

endmodule

>>> verif/variable_record_ring_fifo_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Variable-length record ring FIFO testbench
// Drives push, pop, peek and clear items into the record ring and checks every
// result against an in-bench prediction of the ring contents and pointers.
// Directed tests cover empty reads, short and truncated records, refused
// records, a long hold on the result side that backs the block up, records
// that wrap around the end of the ring and reads of a record whose bytes are
// still arriving. A random phase of well-formed records mixed with reads,
// clears and broken sequences follows.
// ----------------------------------------------------------------------------
module variable_record_ring_fifo_top_test;
   import rvf_pkg::*;

   localparam int unsigned RING_DEPTH   = DEPTH_DEFAULT;
   localparam int unsigned FREE_W       = $clog2(RING_DEPTH + 1);
   localparam int unsigned RANDOM_ITEMS = 80;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PRINT_LIMIT  = 30;

   // One expected result item.
   typedef struct {
      status_type        status;
      logic [7:0]        out_byte;
      logic              has_data;
      logic [6:0]        stored_length;
      logic              last;
      logic [FREE_W-1:0] free_bytes;
      logic              is_empty;
   } record_reply_type;

   // Clock, reset and every block input start at known values.
   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                push          = 1'b0;
   logic [OP_W-1:0]     req_operation = OP_PUSH;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [LEN_W-1:0]    req_length    = '0;
   logic                pop           = 1'b0;
   logic                full;
   logic                empty;
   logic [STATUS_W-1:0] rsp_status;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_has_data;
   logic [LEN_W-1:0]    rsp_stored_length;
   logic                rsp_last;
   logic [FREE_W-1:0]   rsp_free_bytes;
   logic                rsp_is_empty;

   // Predicted ring: contents, which slots were ever written, and pointers.
   logic [7:0]  ring_copy [RING_DEPTH];
   bit          slot_written [RING_DEPTH];
   int unsigned rd_ptr        = 0;
   int unsigned wr_ptr        = 0;
   int unsigned free_count    = RING_DEPTH;
   int unsigned push_left     = 0;
   bit          push_refusing = 1'b0;

   record_reply_type expected_replies [$];

   // Run control and statistics.
   bit          idling_on      = 1'b1;
   bit          hold_requested = 1'b0;
   int unsigned cycle_count    = 0;
   int unsigned mismatch_count = 0;
   int unsigned items_sent     = 0;
   int unsigned results_checked = 0;
   int unsigned full_stalls    = 0;
   int unsigned refused_items  = 0;

   variable_record_ring_fifo_top #(.DEPTH(RING_DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .push              (push),
      .full              (full),
      .req_operation     (req_operation),
      .req_data_byte     (req_data_byte),
      .req_length        (req_length),
      .empty             (empty),
      .pop               (pop),
      .rsp_status        (rsp_status),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_has_data      (rsp_has_data),
      .rsp_stored_length (rsp_stored_length),
      .rsp_last          (rsp_last),
      .rsp_free_bytes    (rsp_free_bytes),
      .rsp_is_empty      (rsp_is_empty)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   function automatic void write_slot(int unsigned idx, logic [7:0] value);
      ring_copy[idx]    = value;
      slot_written[idx] = 1'b1;
   endfunction

   // Every result carries the free count after the item has taken effect.
   function automatic void queue_reply(status_type st, logic [7:0] value, logic has,
                                       logic [6:0] hdr, logic lst);
      record_reply_type r;
      r.status        = st;
      r.out_byte      = value;
      r.has_data      = has;
      r.stored_length = hdr;
      r.last          = lst;
      r.free_bytes    = free_count[FREE_W-1:0];
      r.is_empty      = (free_count >= RING_DEPTH);
      expected_replies.push_back(r);
   endfunction

   // Works out the results of one accepted item and updates the predicted ring.
   function automatic void predict_item(op_type op, logic [7:0] data, logic [6:0] len);
      status_type  st;
      int unsigned hdr;
      int unsigned n;
      int unsigned first;
      st = STATUS_OK;
      case (op)
         OP_PUSH: begin
            if (push_left != 0) begin
               // A continuation byte goes to the next reserved slot.
               if (push_refusing)
                  st = STATUS_FULL;
               else
                  write_slot((wr_ptr + RING_DEPTH - push_left) % RING_DEPTH, data);
               push_left--;
               if (push_left == 0)
                  push_refusing = 1'b0;
            end else if (len > MAX_RECORD || len + 1 > free_count) begin
               // The whole record is refused, byte by byte.
               st            = STATUS_FULL;
               push_left     = (len > 0) ? len - 1 : 0;
               push_refusing = (push_left != 0);
            end else begin
               write_slot(wr_ptr, {1'b0, len});
               if (len > 0)
                  write_slot((wr_ptr + 1) % RING_DEPTH, data);
               wr_ptr        = (wr_ptr + len + 1) % RING_DEPTH;
               free_count    = free_count - (len + 1);
               push_left     = (len > 0) ? len - 1 : 0;
               push_refusing = 1'b0;
            end
            if (st == STATUS_FULL)
               refused_items++;
            queue_reply(st, 8'h00, 1'b0, 7'd0, 1'b1);
         end
         OP_POP, OP_PEEK: begin
            if (free_count >= RING_DEPTH) begin
               queue_reply(STATUS_EMPTY, 8'h00, 1'b0, 7'd0, 1'b1);
            end else begin
               hdr   = ring_copy[rd_ptr];
               n     = (hdr < len) ? hdr : len;
               if (n > MAX_RECORD)
                  n = MAX_RECORD;
               first = (rd_ptr + 1) % RING_DEPTH;
               // Pop removes the whole record even when the reader takes fewer bytes.
               if (op == OP_POP) begin
                  rd_ptr     = (rd_ptr + hdr + 1) % RING_DEPTH;
                  free_count = free_count + hdr + 1;
                  if (free_count > RING_DEPTH)
                     free_count = RING_DEPTH;
               end
               if (n == 0)
                  queue_reply(STATUS_OK, 8'h00, 1'b0, hdr[6:0], 1'b1);
               else
                  for (int i = 0; i < n; i++)
                     queue_reply(STATUS_OK, ring_copy[(first + i) % RING_DEPTH], 1'b1,
                                 hdr[6:0], (i == n - 1));
            end
         end
         default: begin
            // Clear drops everything, including a pending or refused record.
            rd_ptr        = wr_ptr;
            free_count    = RING_DEPTH;
            push_left     = 0;
            push_refusing = 1'b0;
            queue_reply(STATUS_OK, 8'h00, 1'b0, 7'd0, 1'b1);
         end
      endcase
   endfunction

   // Slots that were never written hold unknown data in the block, so a read
   // capacity is cut back to the run of written slots at the head record.
   function automatic logic [6:0] safe_capacity(logic [6:0] cap);
      int unsigned hdr;
      int unsigned n;
      if (free_count >= RING_DEPTH)
         return cap;
      hdr = ring_copy[rd_ptr];
      n   = (hdr < cap) ? hdr : cap;
      if (n > MAX_RECORD)
         n = MAX_RECORD;
      for (int i = 0; i < n; i++)
         if (!slot_written[(rd_ptr + 1 + i) % RING_DEPTH])
            return i[6:0];
      return cap;
   endfunction

   // ------------------------------------------------------------------------
   // Driving and checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] MISMATCH: %s", $realtime, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d: %s is %0h, expected %0h",
                                   results_checked, name, got, want));
   endtask

   // Offers one item, possibly after a random idle burst, and waits until the
   // block takes it. The prediction is made at the accepting edge.
   task automatic send_item(input op_type op, input logic [7:0] data, input logic [6:0] len);
      logic [6:0] eff_len;
      eff_len = len;
      if (op == OP_POP || op == OP_PEEK)
         eff_len = safe_capacity(len);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      push          <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_length    <= eff_len;
      do begin
         @(posedge clock);
         if (full)
            full_stalls++;
      end while (full);
      items_sent++;
      predict_item(op, data, eff_len);
   endtask

   // A whole record: the first byte carries the length, the rest carry noise
   // in their ignored length field.
   task automatic send_record(input int unsigned len);
      send_item(OP_PUSH, 8'($urandom), len[6:0]);
      for (int i = 1; i < len; i++)
         send_item(OP_PUSH, 8'($urandom), 7'($urandom));
   endtask

   // Results are taken whenever pop is high and empty is low; each one is
   // compared with the oldest prediction.
   always @(posedge clock) begin : result_check
      record_reply_type want;
      if (!reset && pop && !empty) begin
         if (expected_replies.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, status %0d",
                                      rsp_status));
         end else begin
            want = expected_replies.pop_front();
            results_checked++;
            check_field("status", rsp_status, want.status);
            check_field("out_byte", rsp_out_byte, want.out_byte);
            check_field("has_data", rsp_has_data, want.has_data);
            check_field("stored_length", rsp_stored_length, want.stored_length);
            check_field("last", rsp_last, want.last);
            check_field("free_bytes", rsp_free_bytes, want.free_bytes);
            check_field("is_empty", rsp_is_empty, want.is_empty);
         end
      end
   end

   // Result side: pop is mostly high, drops in random bursts while idling is
   // on, and drops for one long counted stretch when a test asks for it.
   initial begin : result_drain
      forever begin
         @(posedge clock);
         if (hold_requested) begin
            pop <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_requested = 1'b0;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 18) - 1) @(posedge clock);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_replies.size());
      $display("variable_record_ring_fifo_top test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reads of an empty queue answer empty; clear on an empty queue is harmless.
   task automatic test_empty_queue();
      send_item(OP_POP, 8'h00, 7'd0);
      send_item(OP_PEEK, 8'hFF, 7'd127);
      send_item(OP_CLEAR, 8'h00, 7'd0);
   endtask

   // A short record, a header-only record, truncated reads and zero capacity.
   task automatic test_short_records();
      send_item(OP_PUSH, 8'h00, 7'd3);
      send_item(OP_PUSH, 8'hFF, 7'd127);
      send_item(OP_PUSH, 8'h5A, 7'd0);
      send_item(OP_PUSH, 8'($urandom), 7'd0);
      send_item(OP_PEEK, 8'h00, 7'd64);
      send_item(OP_PEEK, 8'h00, 7'd0);
      send_item(OP_POP, 8'h00, 7'd2);
      send_item(OP_POP, 8'h00, 7'd127);
      send_item(OP_POP, 8'h00, 7'd64);
   endtask

   // Oversized records are refused together with their continuation bytes,
   // and a clear abandons the refused record.
   task automatic test_refused_records();
      send_item(OP_PUSH, 8'h12, 7'd127);
      send_item(OP_PUSH, 8'h34, 7'd5);
      send_item(OP_PUSH, 8'h56, 7'd0);
      send_item(OP_CLEAR, 8'h00, 7'd0);
      send_item(OP_PUSH, 8'h9C, 7'd65);
      send_item(OP_CLEAR, 8'h00, 7'd0);
      send_item(OP_PUSH, 8'h80, 7'd1);
      send_item(OP_POP, 8'h00, 7'd1);
   endtask

   // Holds the result side off for a long stretch while items keep coming,
   // so the block backs up and stalls its input. Long records that a clear
   // abandons walk the write pointer round the ring, so the record that
   // follows wraps past the end of the ring.
   task automatic test_back_pressure();
      hold_requested = 1'b1;
      send_item(OP_CLEAR, 8'h00, 7'd0);
      repeat (7) begin
         send_item(OP_PUSH, 8'($urandom), 7'(MAX_RECORD));
         send_item(OP_CLEAR, 8'h00, 7'd0);
      end
      send_item(OP_PUSH, 8'($urandom), 7'd40);
      send_item(OP_CLEAR, 8'h00, 7'd0);
      send_record(20);
      send_item(OP_POP, 8'h00, 7'd64);
      send_record(5);
      send_item(OP_PEEK, 8'h00, 7'd64);
      send_item(OP_POP, 8'h00, 7'd3);
   endtask

   // Reads the head record while its bytes are still arriving; a read stops
   // short of the first slot that was never written.
   task automatic test_read_while_pushing();
      send_item(OP_CLEAR, 8'h00, 7'd0);
      send_item(OP_PUSH, 8'hC3, 7'd10);
      send_item(OP_PEEK, 8'h00, 7'd64);
      repeat (4) send_item(OP_PUSH, 8'($urandom), 7'($urandom));
      send_item(OP_PEEK, 8'h00, 7'd127);
      repeat (5) send_item(OP_PUSH, 8'($urandom), 7'($urandom));
      send_item(OP_POP, 8'h00, 7'd64);
   endtask

   // Mostly well-formed records with random contents, mixed with reads,
   // clears that cut records short, and refused lengths. The last quarter
   // runs with no idling on either side.
   task automatic test_random_traffic();
      int unsigned pick;
      int unsigned roll;
      logic [6:0]  len;
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS * 3 / 4)
            idling_on = 1'b0;
         pick = $urandom_range(0, 99);
         roll = $urandom_range(0, 19);
         if (push_left != 0 && pick < 85) begin
            send_item(OP_PUSH, 8'($urandom), 7'($urandom));
         end else if (push_left == 0 && pick < 50) begin
            if (roll < 12)
               len = 7'($urandom_range(0, 8));
            else if (roll < 17)
               len = 7'($urandom_range(9, MAX_RECORD));
            else if (roll < 18)
               len = 7'(MAX_RECORD);
            else
               len = 7'($urandom_range(MAX_RECORD + 1, 127));
            send_item(OP_PUSH, 8'($urandom), len);
         end else if (pick < 95) begin
            len = (roll == 0) ? 7'($urandom_range(MAX_RECORD + 1, 127))
                              : 7'($urandom_range(0, MAX_RECORD));
            send_item(pick[0] ? OP_POP : OP_PEEK, 8'($urandom), len);
         end else begin
            send_item(OP_CLEAR, 8'($urandom), 7'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin : main_sequence
      // The ring contents are never cleared, so no slot counts as written yet.
      foreach (slot_written[i]) begin
         slot_written[i] = 1'b0;
         ring_copy[i]    = 8'h00;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_queue();
      test_short_records();
      test_refused_records();
      test_back_pressure();
      test_read_while_pushing();
      test_random_traffic();

      // Wait for every predicted result, then a little longer so that any
      // stray extra result would still be caught.
      push <= 1'b0;
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d items and checked %0d results, %0d of them answered full.",
               items_sent, results_checked, refused_items);
      $display("Input stalled on a backed-up block for %0d cycles; %0d mismatches.",
               full_stalls, mismatch_count);
      if (mismatch_count == 0)
         $display("variable_record_ring_fifo_top test passed");
      else
         $display("variable_record_ring_fifo_top test failed");
      $finish;
   end

endmodule
